// ===== rtl/core/sphav_pkg.sv =====
// Shared types, constants and fixed-point helpers of the SPH artificial viscosity block.
`timescale 1ns / 1ps

package sphav_pkg;

    localparam int PARTICLE_COUNT_DEF = 1024;
    localparam int DIMENSIONS_DEF     = 2;
    localparam int MAX_DIM            = 3;

    localparam int DATA_W   = 32;
    localparam int GAIN_W   = 20;
    localparam int INDEX_W  = 10;
    localparam int SEL_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd163840;

    // 0.01 in Q16.16
    localparam logic signed [DATA_W-1:0] SOFT_Q = 32'sd655;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_PAIR  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUADRATIC_GAIN = 2'd1;

    localparam logic [SEL_W-1:0] ATTR_VEL    = 4'd0;
    localparam logic [SEL_W-1:0] ATTR_POS    = 4'd3;
    localparam logic [SEL_W-1:0] ATTR_H      = 4'd6;
    localparam logic [SEL_W-1:0] ATTR_C      = 4'd7;
    localparam logic [SEL_W-1:0] ATTR_RHO    = 4'd8;
    localparam logic [SEL_W-1:0] ATTR_MASS   = 4'd9;
    localparam logic [SEL_W-1:0] ATTR_ACC    = 4'd10;
    localparam logic [SEL_W-1:0] ATTR_ENERGY = 4'd13;
    localparam logic [SEL_W-1:0] ATTR_SPARE0 = 4'd14;
    localparam logic [SEL_W-1:0] ATTR_SPARE1 = 4'd15;

    typedef struct packed {
        logic [1:0]                action;
        logic [INDEX_W-1:0]        first_index;
        logic [INDEX_W-1:0]        second_index;
        logic [SEL_W-1:0]          attribute_select;
        logic signed [DATA_W-1:0]  attribute_value;
        logic signed [DATA_W-1:0]  kernel_gradient_x;
        logic signed [DATA_W-1:0]  kernel_gradient_y;
        logic signed [DATA_W-1:0]  kernel_gradient_z;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        logic                      pair_approaching;
        logic                      saturated;
    } t_out_word;

    // {clip, value}: clamp to signed 32 bits
    function automatic logic [32:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (x < -66'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b0, x[31:0]};
        end
    endfunction

    // Q16.16 product: floor shift then clamp
    function automatic logic [32:0] qsat(input logic signed [63:0] p);
        return sat32(66'(p >>> 16));
    endfunction

    function automatic logic signed [31:0] avg2(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        return 32'(s >>> 1);
    endfunction

endpackage

// ===== rtl/core/sph_artificial_viscosity.sv =====
// Top level of the SPH artificial viscosity block: particle store and pair sequencer.
`timescale 1ns / 1ps

// Usage
//   Input channel i_in_valid / o_in_stall carries one command word: write an
//   attribute, read an attribute, or process an interaction pair. Every command
//   gives exactly one result word on o_out_valid / i_out_stall.
//   Configuration port i_cfg_valid / o_cfg_ready writes the two viscosity gains;
//   write it only while no command is in flight.
//   One command is worked at a time. A pair that is not approaching ends after
//   the gather of differences; an approaching pair goes on to the viscosity term
//   and the updates. All particle attributes live in one single-port-write,
//   registered-read memory, so the pair cost is set by one memory access and
//   one 32x32 multiply per cycle, plus two 64-step bit-serial divisions.
//   Reset clears the control state and restores both gains to 2.5; the store
//   holds nothing defined until written and needs no clearing pass.
//   The result word sits in an output register: while the receiver stalls the
//   block still takes the next command, and stops only when a second result
//   would have to overwrite the waiting one.
module sph_artificial_viscosity
    import sphav_pkg::*;
#(
    parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF,
    parameter int DIMENSIONS     = DIMENSIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    localparam int PW    = $clog2(PARTICLE_COUNT);
    localparam int AW    = PW + SEL_W;
    localparam int DEPTH = 2 ** AW;
    localparam logic [16:0]      PCOUNT = 17'(PARTICLE_COUNT);
    localparam logic [SEL_W-1:0] DIM4   = SEL_W'(DIMENSIONS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_RDW  = 8'b0000_0100,
        S_GATH = 8'b0000_1000,
        S_SCAL = 8'b0001_0000,
        S_ACC  = 8'b0010_0000,
        S_DONE = 8'b0100_0000
    } t_state;

    t_state r_state, n_state;
    logic [4:0]  r_sub, n_sub;
    logic [1:0]  r_d, n_d;
    t_in_word    r_in, n_in;

    logic signed [31:0] r_a, n_a;
    logic signed [31:0] r_h, n_h;
    logic signed [31:0] r_c, n_c;
    logic signed [31:0] r_rho, n_rho;
    logic signed [31:0] r_mi, n_mi;
    logic signed [31:0] r_mj, n_mj;
    logic signed [31:0] r_vd, n_vd;
    logic signed [31:0] r_m2, n_m2;
    logic signed [31:0] r_t, n_t;
    logic signed [31:0] r_den, n_den;
    logic signed [31:0] r_phi, n_phi;
    logic signed [31:0] r_lin, n_lin;
    logic signed [31:0] r_pi, n_pi;
    logic signed [31:0] r_aux, n_aux;
    logic signed [31:0] r_half, n_half;
    logic signed [31:0] r_dr, n_dr;
    logic signed [31:0] r_dv [0:MAX_DIM-1];
    logic signed [31:0] n_dv [0:MAX_DIM-1];
    logic signed [50:0] r_vdr, n_vdr;
    logic signed [50:0] r_mod2, n_mod2;
    logic signed [63:0] r_prod;
    logic               r_clip, n_clip;
    logic               r_appr, n_appr;
    logic signed [31:0] r_rd, n_rd;
    logic               r_ovalid, n_ovalid;
    t_out_word          r_out, n_out;
    logic [GAIN_W-1:0]  r_alpha;
    logic [GAIN_W-1:0]  r_beta;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;
    logic signed [31:0] rdata_s;

    logic               mul_en;
    logic signed [31:0] m_a, m_b;
    logic               div_start;
    logic signed [63:0] div_num;
    logic signed [31:0] div_den;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic               div_clip;

    logic [32:0]        q_prod;
    logic signed [31:0] q_val;
    logic [32:0]        s_a;
    logic [32:0]        s_b;
    logic               attr_ok;
    logic               pair_ok;
    logic               last_d;
    logic signed [31:0] grad_d;
    logic [SEL_W-1:0]   sel;

    function automatic logic [AW-1:0] f_addr(input logic [INDEX_W-1:0] p,
                                             input logic [SEL_W-1:0] slot);
        return {PW'(p), slot};
    endfunction

    sphav_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sphav_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_clip  (div_clip)
    );

    assign rdata_s = $signed(ram_rdata);
    assign q_prod  = qsat(r_prod);
    assign q_val   = $signed(q_prod[31:0]);
    assign sel     = r_in.attribute_select;
    assign last_d  = (r_d == 2'(DIMENSIONS - 1));
    assign pair_ok = (17'(r_in.first_index) < PCOUNT) && (17'(r_in.second_index) < PCOUNT);

    always_comb begin
        attr_ok = 1'b0;
        if (17'(r_in.first_index) < PCOUNT) begin
            if (sel < ATTR_POS) begin
                attr_ok = (sel < DIM4);
            end else if (sel < ATTR_H) begin
                attr_ok = (sel - ATTR_POS < DIM4);
            end else if (sel < ATTR_ACC) begin
                attr_ok = 1'b1;
            end else if (sel < ATTR_ENERGY) begin
                attr_ok = (sel - ATTR_ACC < DIM4);
            end else begin
                attr_ok = (sel == ATTR_ENERGY);
            end
        end
    end

    always_comb begin
        case (r_d)
            2'd0:    grad_d = r_in.kernel_gradient_x;
            2'd1:    grad_d = r_in.kernel_gradient_y;
            default: grad_d = r_in.kernel_gradient_z;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_sub   = r_sub;
        n_d     = r_d;
        n_in    = r_in;
        n_a     = r_a;
        n_h     = r_h;
        n_c     = r_c;
        n_rho   = r_rho;
        n_mi    = r_mi;
        n_mj    = r_mj;
        n_vd    = r_vd;
        n_m2    = r_m2;
        n_t     = r_t;
        n_den   = r_den;
        n_phi   = r_phi;
        n_lin   = r_lin;
        n_pi    = r_pi;
        n_aux   = r_aux;
        n_half  = r_half;
        n_dr    = r_dr;
        n_dv    = r_dv;
        n_vdr   = r_vdr;
        n_mod2  = r_mod2;
        n_clip  = r_clip;
        n_appr  = r_appr;
        n_rd    = r_rd;
        n_out   = r_out;
        n_ovalid = (r_ovalid && !i_out_stall) ? 1'b0 : r_ovalid;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        mul_en    = 1'b0;
        m_a       = '0;
        m_b       = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        s_a       = '0;
        s_b       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_word;
                    n_sub   = '0;
                    n_d     = '0;
                    n_vdr   = '0;
                    n_mod2  = '0;
                    n_clip  = 1'b0;
                    n_appr  = 1'b0;
                    n_rd    = '0;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_DONE;
                case (r_in.action)
                    ACT_WRITE: begin
                        ram_we    = attr_ok;
                        ram_waddr = f_addr(r_in.first_index, sel);
                        ram_wdata = r_in.attribute_value;
                    end
                    ACT_READ: begin
                        ram_raddr = f_addr(r_in.first_index, sel);
                        if (attr_ok) begin
                            n_state = S_RDW;
                        end
                    end
                    ACT_PAIR: begin
                        if (pair_ok) begin
                            n_state = S_GATH;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_RDW: begin
                n_rd    = rdata_s;
                n_state = S_DONE;
            end

            // velocity and position differences, dot product and |dr|^2
            S_GATH: begin
                n_sub = r_sub + 5'd1;
                case (r_sub)
                    5'd0: begin
                        ram_raddr = f_addr(r_in.first_index, ATTR_VEL + SEL_W'(r_d));
                    end
                    5'd1: begin
                        ram_raddr = f_addr(r_in.second_index, ATTR_VEL + SEL_W'(r_d));
                        n_a = rdata_s;
                    end
                    5'd2: begin
                        ram_raddr = f_addr(r_in.first_index, ATTR_POS + SEL_W'(r_d));
                        s_a = sat32(66'(r_a) - 66'(rdata_s));
                        n_dv[r_d] = $signed(s_a[31:0]);
                        n_clip = r_clip | s_a[32];
                    end
                    5'd3: begin
                        ram_raddr = f_addr(r_in.second_index, ATTR_POS + SEL_W'(r_d));
                        n_a = rdata_s;
                    end
                    5'd4: begin
                        s_a = sat32(66'(r_a) - 66'(rdata_s));
                        n_dr = $signed(s_a[31:0]);
                        n_clip = r_clip | s_a[32];
                    end
                    5'd5: begin
                        mul_en = 1'b1;
                        m_a = r_dv[r_d];
                        m_b = r_dr;
                    end
                    5'd6: begin
                        n_vdr = r_vdr + 51'(r_prod >>> 16);
                        mul_en = 1'b1;
                        m_a = r_dr;
                        m_b = r_dr;
                    end
                    default: begin
                        n_mod2 = r_mod2 + 51'(r_prod >>> 16);
                        n_sub  = '0;
                        if (last_d) begin
                            if (r_vdr[50]) begin
                                n_appr  = 1'b1;
                                n_state = S_SCAL;
                            end else begin
                                n_state = S_DONE;
                            end
                        end else begin
                            n_d = r_d + 2'd1;
                        end
                    end
                endcase
            end

            // pair averages, softened denominator and the viscosity term
            S_SCAL: begin
                n_sub = r_sub + 5'd1;
                case (r_sub)
                    5'd0: ram_raddr = f_addr(r_in.first_index, ATTR_H);
                    5'd1: begin
                        ram_raddr = f_addr(r_in.second_index, ATTR_H);
                        n_a = rdata_s;
                    end
                    5'd2: begin
                        ram_raddr = f_addr(r_in.first_index, ATTR_C);
                        n_h = avg2(r_a, rdata_s);
                    end
                    5'd3: begin
                        ram_raddr = f_addr(r_in.second_index, ATTR_C);
                        n_a = rdata_s;
                    end
                    5'd4: begin
                        ram_raddr = f_addr(r_in.first_index, ATTR_RHO);
                        n_c = avg2(r_a, rdata_s);
                    end
                    5'd5: begin
                        ram_raddr = f_addr(r_in.second_index, ATTR_RHO);
                        n_a = rdata_s;
                    end
                    5'd6: begin
                        ram_raddr = f_addr(r_in.first_index, ATTR_MASS);
                        n_rho = avg2(r_a, rdata_s);
                    end
                    5'd7: begin
                        ram_raddr = f_addr(r_in.second_index, ATTR_MASS);
                        n_mi = rdata_s;
                        s_a = sat32(66'(r_vdr));
                        s_b = sat32(66'(r_mod2));
                        n_vd = $signed(s_a[31:0]);
                        n_m2 = $signed(s_b[31:0]);
                        n_clip = r_clip | s_a[32] | s_b[32];
                    end
                    5'd8: begin
                        n_mj = rdata_s;
                        mul_en = 1'b1;
                        m_a = r_h;
                        m_b = r_h;
                    end
                    5'd9: begin
                        n_t = q_val;
                        n_clip = r_clip | q_prod[32];
                    end
                    5'd10: begin
                        mul_en = 1'b1;
                        m_a = r_t;
                        m_b = SOFT_Q;
                    end
                    5'd11: begin
                        s_a = sat32(66'(r_m2) + 66'(r_prod >>> 16));
                        n_den = $signed(s_a[31:0]);
                        n_clip = r_clip | s_a[32];
                        mul_en = 1'b1;
                        m_a = r_h;
                        m_b = r_vd;
                    end
                    5'd12: begin
                        div_start = 1'b1;
                        div_num   = r_prod;
                        div_den   = r_den;
                    end
                    5'd13: begin
                        // hold until the quotient is ready
                        n_sub = r_sub;
                        if (div_done) begin
                            n_phi  = div_quot;
                            n_clip = r_clip | div_clip;
                            n_sub  = r_sub + 5'd1;
                        end
                    end
                    5'd14: begin
                        mul_en = 1'b1;
                        m_a = $signed({12'b0, r_alpha});
                        m_b = r_c;
                    end
                    5'd15: begin
                        n_t = q_val;
                        n_clip = r_clip | q_prod[32];
                    end
                    5'd16: begin
                        mul_en = 1'b1;
                        m_a = r_t;
                        m_b = r_phi;
                    end
                    5'd17: begin
                        n_lin = q_val;
                        n_clip = r_clip | q_prod[32];
                        mul_en = 1'b1;
                        m_a = r_phi;
                        m_b = r_phi;
                    end
                    5'd18: begin
                        n_t = q_val;
                        n_clip = r_clip | q_prod[32];
                    end
                    5'd19: begin
                        mul_en = 1'b1;
                        m_a = $signed({12'b0, r_beta});
                        m_b = r_t;
                    end
                    5'd20: begin
                        s_a = sat32(66'(q_val) - 66'(r_lin));
                        n_t = $signed(s_a[31:0]);
                        n_clip = r_clip | q_prod[32] | s_a[32];
                    end
                    5'd21: begin
                        div_start = 1'b1;
                        div_num   = $signed({{16{r_t[31]}}, r_t, 16'b0});
                        div_den   = r_rho;
                    end
                    default: begin
                        n_sub = r_sub;
                        if (div_done) begin
                            n_pi    = div_quot;
                            n_clip  = r_clip | div_clip;
                            n_sub   = '0;
                            n_d     = '0;
                            n_state = S_ACC;
                        end
                    end
                endcase
            end

            // read-modify-write of both accelerations and energy rates
            S_ACC: begin
                n_sub = r_sub + 5'd1;
                case (r_sub)
                    5'd0: begin
                        ram_raddr = f_addr(r_in.first_index, ATTR_ACC + SEL_W'(r_d));
                        mul_en = 1'b1;
                        m_a = r_pi;
                        m_b = grad_d;
                    end
                    5'd1: begin
                        n_a = rdata_s;
                        s_a = sat32(-66'(q_val));
                        n_aux = $signed(s_a[31:0]);
                        n_clip = r_clip | q_prod[32] | s_a[32];
                    end
                    5'd2: begin
                        mul_en = 1'b1;
                        m_a = r_aux;
                        m_b = r_mj;
                    end
                    5'd3: begin
                        s_a = sat32(66'(r_a) + 66'(q_val));
                        ram_we    = 1'b1;
                        ram_waddr = f_addr(r_in.first_index, ATTR_ACC + SEL_W'(r_d));
                        ram_wdata = s_a[31:0];
                        n_clip = r_clip | q_prod[32] | s_a[32];
                        ram_raddr = f_addr(r_in.second_index, ATTR_ACC + SEL_W'(r_d));
                    end
                    5'd4: begin
                        n_a = rdata_s;
                        mul_en = 1'b1;
                        m_a = r_aux;
                        m_b = r_mi;
                    end
                    5'd5: begin
                        s_a = sat32(66'(r_a) - 66'(q_val));
                        ram_we    = 1'b1;
                        ram_waddr = f_addr(r_in.second_index, ATTR_ACC + SEL_W'(r_d));
                        ram_wdata = s_a[31:0];
                        n_clip = r_clip | q_prod[32] | s_a[32];
                        mul_en = 1'b1;
                        m_a = r_aux;
                        m_b = r_dv[r_d];
                    end
                    5'd6: begin
                        n_half = q_val >>> 1;
                        n_clip = r_clip | q_prod[32];
                        ram_raddr = f_addr(r_in.first_index, ATTR_ENERGY);
                    end
                    5'd7: begin
                        n_a = rdata_s;
                        mul_en = 1'b1;
                        m_a = r_half;
                        m_b = r_mj;
                    end
                    5'd8: begin
                        s_a = sat32(66'(r_a) - 66'(q_val));
                        ram_we    = 1'b1;
                        ram_waddr = f_addr(r_in.first_index, ATTR_ENERGY);
                        ram_wdata = s_a[31:0];
                        n_clip = r_clip | q_prod[32] | s_a[32];
                        ram_raddr = f_addr(r_in.second_index, ATTR_ENERGY);
                    end
                    5'd9: begin
                        n_a = rdata_s;
                        mul_en = 1'b1;
                        m_a = r_half;
                        m_b = r_mi;
                    end
                    default: begin
                        s_a = sat32(66'(r_a) - 66'(q_val));
                        ram_we    = 1'b1;
                        ram_waddr = f_addr(r_in.second_index, ATTR_ENERGY);
                        ram_wdata = s_a[31:0];
                        n_clip = r_clip | q_prod[32] | s_a[32];
                        n_sub  = '0;
                        if (last_d) begin
                            n_state = S_DONE;
                        end else begin
                            n_d = r_d + 2'd1;
                        end
                    end
                endcase
            end

            S_DONE: begin
                // hand over once the output register is free or being drained
                if (!r_ovalid || !i_out_stall) begin
                    n_out.read_value       = r_rd;
                    n_out.pair_approaching = r_appr;
                    n_out.saturated        = r_clip;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_alpha  <= GAIN_RESET;
            r_beta   <= GAIN_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && i_cfg_index == CFG_LINEAR_GAIN) begin
                r_alpha <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == CFG_QUADRATIC_GAIN) begin
                r_beta <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sub  <= n_sub;
        r_d    <= n_d;
        r_in   <= n_in;
        r_a    <= n_a;
        r_h    <= n_h;
        r_c    <= n_c;
        r_rho  <= n_rho;
        r_mi   <= n_mi;
        r_mj   <= n_mj;
        r_vd   <= n_vd;
        r_m2   <= n_m2;
        r_t    <= n_t;
        r_den  <= n_den;
        r_phi  <= n_phi;
        r_lin  <= n_lin;
        r_pi   <= n_pi;
        r_aux  <= n_aux;
        r_half <= n_half;
        r_dr   <= n_dr;
        r_dv   <= n_dv;
        r_vdr  <= n_vdr;
        r_mod2 <= n_mod2;
        r_clip <= n_clip;
        r_appr <= n_appr;
        r_rd   <= n_rd;
        r_out  <= n_out;
        if (mul_en) begin
            r_prod <= m_a * m_b;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/core/sphav_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module sphav_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sphav_div.sv =====
// Bit-serial signed divider, truncating, with clamped 32-bit quotient.
`timescale 1ns / 1ps

module sphav_div
    import sphav_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [63:0]       i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quot,
    output logic                     o_clip
);

    localparam int STEPS = 64;
    localparam int CW    = $clog2(STEPS);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_dmag;
    logic          r_neg;
    logic          r_nneg;
    logic          r_nzero;
    logic          r_dzero;

    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_q[63]};
    assign diff  = trial - {1'b0, r_dmag};
    assign ge    = (trial >= {1'b0, r_dmag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q     <= i_num[63] ? 64'(-i_num) : 64'(i_num);
            r_rem   <= '0;
            r_dmag  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            r_neg   <= i_num[63] ^ i_den[31];
            r_nneg  <= i_num[63];
            r_nzero <= (i_num == 64'sd0);
            r_dzero <= (i_den == 32'sd0);
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : trial[31:0];
            r_q   <= {r_q[62:0], ge};
        end
    end

    always_comb begin
        o_clip = 1'b0;
        if (r_dzero) begin
            if (r_nzero) begin
                o_quot = '0;
            end else begin
                o_clip = 1'b1;
                o_quot = r_nneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end else if (r_neg) begin
            if (r_q > 64'h8000_0000) begin
                o_clip = 1'b1;
                o_quot = 32'sh8000_0000;
            end else begin
                o_quot = $signed(-r_q[31:0]);
            end
        end else begin
            if (r_q > 64'h7FFF_FFFF) begin
                o_clip = 1'b1;
                o_quot = 32'sh7FFF_FFFF;
            end else begin
                o_quot = $signed(r_q[31:0]);
            end
        end
    end

    assign o_done = r_done;

endmodule

// ===== verif/sphav_checker.sv =====
// Predictor and scoreboard of the SPH artificial viscosity block: watches the channels and compares.
`timescale 1ns / 1ps

module sphav_checker
    import sphav_pkg::*;
#(
    parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF,
    parameter int DIMENSIONS     = DIMENSIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_word             i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_word            i_out_word,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    int vel_mem [PARTICLE_COUNT*DIMENSIONS];
    int pos_mem [PARTICLE_COUNT*DIMENSIONS];
    int acc_mem [PARTICLE_COUNT*DIMENSIONS];
    int h_mem   [PARTICLE_COUNT];
    int c_mem   [PARTICLE_COUNT];
    int rho_mem [PARTICLE_COUNT];
    int mass_mem[PARTICLE_COUNT];
    int erate_mem[PARTICLE_COUNT];
    logic [GAIN_W-1:0] alpha_gain;
    logic [GAIN_W-1:0] beta_gain;
    logic              clipped;
    t_out_word         result_q[$];

    function automatic longint clamp32(longint x);
        if (x > QMAX) begin
            clipped = 1'b1;
            return QMAX;
        end
        if (x < QMIN) begin
            clipped = 1'b1;
            return QMIN;
        end
        return x;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return clamp32((a * b) >>> 16);
    endfunction

    function automatic longint fx_div(longint num, longint den);
        if (den == 0) begin
            if (num == 0) return 0;
            clipped = 1'b1;
            return (num > 0) ? QMAX : QMIN;
        end
        return clamp32(num / den);
    endfunction

    // Accumulate the viscosity of one pair; returns whether the pair approaches.
    function automatic logic viscosity_pair(int i, int j, longint grad[3]);
        longint dv[DIMENSIONS];
        longint dr, vdr, mod2, vd, m2, h, c, rho, hsq, soft_term, den, phi;
        longint t1, lin, p2, quad, numer, pi_term, mi, mj, aux, half;
        vdr  = 0;
        mod2 = 0;
        for (int d = 0; d < DIMENSIONS; d++) begin
            dv[d] = clamp32(longint'(vel_mem[i*DIMENSIONS+d]) - vel_mem[j*DIMENSIONS+d]);
            dr    = clamp32(longint'(pos_mem[i*DIMENSIONS+d]) - pos_mem[j*DIMENSIONS+d]);
            vdr  += (dv[d] * dr) >>> 16;
            mod2 += (dr * dr) >>> 16;
        end
        if (vdr >= 0) return 1'b0;
        vd        = clamp32(vdr);
        m2        = clamp32(mod2);
        h         = (longint'(h_mem[i]) + h_mem[j]) >>> 1;
        c         = (longint'(c_mem[i]) + c_mem[j]) >>> 1;
        rho       = (longint'(rho_mem[i]) + rho_mem[j]) >>> 1;
        hsq       = fx_mul(h, h);
        soft_term = (hsq * longint'(SOFT_Q)) >>> 16;
        den       = clamp32(m2 + soft_term);
        phi       = fx_div(h * vd, den);
        t1        = fx_mul(longint'(alpha_gain), c);
        lin       = fx_mul(t1, phi);
        p2        = fx_mul(phi, phi);
        quad      = fx_mul(longint'(beta_gain), p2);
        numer     = clamp32(quad - lin);
        pi_term   = fx_div(numer * 65536, rho);
        mi        = mass_mem[i];
        mj        = mass_mem[j];
        for (int d = 0; d < DIMENSIONS; d++) begin
            aux  = clamp32(-fx_mul(pi_term, grad[d]));
            acc_mem[i*DIMENSIONS+d] =
                int'(clamp32(longint'(acc_mem[i*DIMENSIONS+d]) + fx_mul(aux, mj)));
            acc_mem[j*DIMENSIONS+d] =
                int'(clamp32(longint'(acc_mem[j*DIMENSIONS+d]) - fx_mul(aux, mi)));
            half = fx_mul(aux, dv[d]) >>> 1;
            erate_mem[i] = int'(clamp32(longint'(erate_mem[i]) - fx_mul(half, mj)));
            erate_mem[j] = int'(clamp32(longint'(erate_mem[j]) - fx_mul(half, mi)));
        end
        return 1'b1;
    endfunction

    function automatic t_out_word predict_result(t_in_word w);
        t_out_word r;
        int        i, j, sel;
        longint    grad[3];
        r       = '0;
        clipped = 1'b0;
        i       = int'(w.first_index);
        j       = int'(w.second_index);
        sel     = int'(w.attribute_select);
        if (w.action == ACT_WRITE && i < PARTICLE_COUNT) begin
            if (sel < ATTR_POS) begin
                if (sel < DIMENSIONS) vel_mem[i*DIMENSIONS+sel] = w.attribute_value;
            end else if (sel < ATTR_H) begin
                if (sel - ATTR_POS < DIMENSIONS)
                    pos_mem[i*DIMENSIONS+sel-ATTR_POS] = w.attribute_value;
            end else if (sel >= ATTR_ACC && sel < ATTR_ENERGY) begin
                if (sel - ATTR_ACC < DIMENSIONS)
                    acc_mem[i*DIMENSIONS+sel-ATTR_ACC] = w.attribute_value;
            end else begin
                case (w.attribute_select)
                    ATTR_H:      h_mem[i]     = w.attribute_value;
                    ATTR_C:      c_mem[i]     = w.attribute_value;
                    ATTR_RHO:    rho_mem[i]   = w.attribute_value;
                    ATTR_MASS:   mass_mem[i]  = w.attribute_value;
                    ATTR_ENERGY: erate_mem[i] = w.attribute_value;
                    default: ;
                endcase
            end
        end else if (w.action == ACT_READ && i < PARTICLE_COUNT) begin
            if (sel < ATTR_POS) begin
                if (sel < DIMENSIONS) r.read_value = vel_mem[i*DIMENSIONS+sel];
            end else if (sel < ATTR_H) begin
                if (sel - ATTR_POS < DIMENSIONS)
                    r.read_value = pos_mem[i*DIMENSIONS+sel-ATTR_POS];
            end else if (sel >= ATTR_ACC && sel < ATTR_ENERGY) begin
                if (sel - ATTR_ACC < DIMENSIONS)
                    r.read_value = acc_mem[i*DIMENSIONS+sel-ATTR_ACC];
            end else begin
                case (w.attribute_select)
                    ATTR_H:      r.read_value = h_mem[i];
                    ATTR_C:      r.read_value = c_mem[i];
                    ATTR_RHO:    r.read_value = rho_mem[i];
                    ATTR_MASS:   r.read_value = mass_mem[i];
                    ATTR_ENERGY: r.read_value = erate_mem[i];
                    default: ;
                endcase
            end
        end else if (w.action == ACT_PAIR && i < PARTICLE_COUNT && j < PARTICLE_COUNT) begin
            grad[0] = longint'(w.kernel_gradient_x);
            grad[1] = longint'(w.kernel_gradient_y);
            grad[2] = longint'(w.kernel_gradient_z);
            r.pair_approaching = viscosity_pair(i, j, grad);
        end
        r.saturated = clipped;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            alpha_gain   = GAIN_RESET;
            beta_gain    = GAIN_RESET;
            o_fail_count = 0;
            result_q.delete();
            for (int k = 0; k < PARTICLE_COUNT*DIMENSIONS; k++) begin
                vel_mem[k] = 0;
                pos_mem[k] = 0;
                acc_mem[k] = 0;
            end
            for (int k = 0; k < PARTICLE_COUNT; k++) begin
                h_mem[k]     = 0;
                c_mem[k]     = 0;
                rho_mem[k]   = 0;
                mass_mem[k]  = 0;
                erate_mem[k] = 0;
            end
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result word with nothing expected: %p", $time, i_out_word);
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (want.read_value !== i_out_word.read_value) begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 want.read_value, i_out_word.read_value);
                        o_fail_count++;
                    end
                    if (want.pair_approaching !== i_out_word.pair_approaching) begin
                        $display("%0t: pair_approaching expected %b actual %b", $time,
                                 want.pair_approaching, i_out_word.pair_approaching);
                        o_fail_count++;
                    end
                    if (want.saturated !== i_out_word.saturated) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, i_out_word.saturated);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_LINEAR_GAIN) alpha_gain = i_cfg_data;
                else if (i_cfg_index == CFG_QUADRATIC_GAIN) beta_gain = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) result_q.push_back(predict_result(i_in_word));
        end
        o_pending = result_q.size();
    end

endmodule

// ===== verif/tb_sph_artificial_viscosity.sv =====
// Testbench top of the SPH artificial viscosity block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sph_artificial_viscosity;
    import sphav_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 120;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_word   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [GAIN_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 o_cfg_ready;
    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    int                   burst_left  = 0;
    int                   stall_left  = 0;
    int                   stall_mode  = 0;
    logic [INDEX_W-1:0]   particle_pool[17];

    always #6 i_clk = ~i_clk;

    sph_artificial_viscosity u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sphav_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stalls in stretches: none, light, heavy
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic int attr_value(int sel);
        case ($urandom_range(0, 15))
            0: return $urandom();
            1: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: ;
        endcase
        if (sel >= ATTR_H && sel <= ATTR_MASS) return $urandom_range(1, 32'h4_0000);
        return int'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
    endfunction

    function automatic int live_select();
        int pick;
        pick = $urandom_range(0, 10);
        if (pick < 2) return ATTR_VEL + pick;
        if (pick < 4) return ATTR_POS + pick - 2;
        if (pick < 8) return ATTR_H + pick - 4;
        if (pick < 10) return ATTR_ACC + pick - 8;
        return ATTR_ENERGY;
    endfunction

    function automatic int dead_select();
        case ($urandom_range(0, 4))
            0: return ATTR_VEL + 2;
            1: return ATTR_POS + 2;
            2: return ATTR_ACC + 2;
            3: return ATTR_SPARE0;
            default: return ATTR_SPARE1;
        endcase
    endfunction

    function automatic t_in_word make_word(logic [1:0] act, int i, int j, int sel, int val);
        t_in_word w;
        w.action            = act;
        w.first_index       = INDEX_W'(i);
        w.second_index      = INDEX_W'(j);
        w.attribute_select  = SEL_W'(sel);
        w.attribute_value   = val;
        w.kernel_gradient_x = int'($urandom_range(0, 32'h2_0000)) - 32'h1_0000;
        w.kernel_gradient_y = int'($urandom_range(0, 32'h2_0000)) - 32'h1_0000;
        w.kernel_gradient_z = $urandom();
        if ($urandom_range(0, 15) == 0) begin
            w.kernel_gradient_x = $urandom();
            w.kernel_gradient_y = $urandom();
        end
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drain the block until every expected result is taken, then wait out SETTLE before touching registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] gain);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int i, j, sel, roll;
        logic [GAIN_W-1:0] alpha, beta;
        for (int k = 0; k < 16; k++) particle_pool[k] = INDEX_W'(k);
        particle_pool[16] = 10'd1023;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every live attribute of the pool so nothing undefined is touched
        foreach (particle_pool[p]) begin
            for (int s = 0; s <= ATTR_ENERGY; s++) begin
                if (s == ATTR_VEL + 2 || s == ATTR_POS + 2 || s == ATTR_ACC + 2) continue;
                send_word(make_word(ACT_WRITE, int'(particle_pool[p]), 0, s, attr_value(s)));
            end
        end

        // Head-on pair 0/1, then zero density, extremes, same particle, unused selects
        send_word(make_word(ACT_WRITE, 0, 0, ATTR_POS, 0));
        send_word(make_word(ACT_WRITE, 0, 0, ATTR_POS + 1, 0));
        send_word(make_word(ACT_WRITE, 0, 0, ATTR_VEL, 32'h1_0000));
        send_word(make_word(ACT_WRITE, 0, 0, ATTR_VEL + 1, 0));
        send_word(make_word(ACT_WRITE, 1, 0, ATTR_POS, 32'h1_0000));
        send_word(make_word(ACT_WRITE, 1, 0, ATTR_POS + 1, 0));
        send_word(make_word(ACT_WRITE, 1, 0, ATTR_VEL, 0));
        send_word(make_word(ACT_WRITE, 1, 0, ATTR_VEL + 1, 0));
        send_word(make_word(ACT_WRITE, 0, 0, ATTR_RHO, 0));
        send_word(make_word(ACT_WRITE, 1, 0, ATTR_RHO, 0));
        send_word(make_word(ACT_PAIR, 0, 1, 0, 0));
        send_word(make_word(ACT_WRITE, 0, 0, ATTR_RHO, 32'h1_0000));
        send_word(make_word(ACT_WRITE, 1, 0, ATTR_MASS, 32'h7FFF_FFFF));
        begin
            t_in_word w;
            w = make_word(ACT_PAIR, 0, 1, 0, 0);
            w.kernel_gradient_x = 32'h7FFF_FFFF;
            w.kernel_gradient_y = 32'h8000_0000;
            send_word(w);
        end
        send_word(make_word(ACT_PAIR, 1023, 1023, 0, 0));
        send_word(make_word(ACT_READ, 0, 0, ATTR_ACC, 0));
        send_word(make_word(ACT_READ, 1, 0, ATTR_ENERGY, 0));
        send_word(make_word(ACT_READ, 1, 0, ATTR_MASS, 0));
        send_word(make_word(ACT_WRITE, 1023, 0, ATTR_SPARE0, -1));
        send_word(make_word(ACT_WRITE, 1023, 0, ATTR_VEL + 2, -1));
        send_word(make_word(ACT_READ, 1023, 0, ATTR_SPARE1, 0));
        send_word(make_word(ACT_READ, 1023, 0, ATTR_ACC + 2, 0));
        send_word(make_word(ACT_NOP, 1023, 1023, ATTR_SPARE1, -1));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin alpha = '0; beta = 20'd655360; end
                1: begin alpha = 20'd655360; beta = '0; end
                2: begin alpha = 20'd655360; beta = 20'd655360; end
                3: begin alpha = GAIN_RESET; beta = GAIN_RESET; end
                default: begin
                    alpha = GAIN_W'($urandom_range(0, 655360));
                    beta  = GAIN_W'($urandom_range(0, 655360));
                end
            endcase
            write_gain(CFG_LINEAR_GAIN, alpha);
            write_gain(CFG_QUADRATIC_GAIN, beta);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                i    = int'(particle_pool[$urandom_range(0, 16)]);
                j    = int'(particle_pool[$urandom_range(0, 16)]);
                if (roll < 30) begin
                    sel = live_select();
                    send_word(make_word(ACT_WRITE, i, j, sel, attr_value(sel)));
                end else if (roll < 38) begin
                    send_word(make_word(ACT_READ, i, j, live_select(), $urandom()));
                end else if (roll < 42) begin
                    send_word(make_word(($urandom_range(0, 1) == 1) ? ACT_READ : ACT_WRITE,
                                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                                        dead_select(), $urandom()));
                end else if (roll < 95) begin
                    send_word(make_word(ACT_PAIR, i, j, $urandom_range(0, 15), $urandom()));
                end else begin
                    send_word(make_word(ACT_NOP, $urandom_range(0, 1023),
                                        $urandom_range(0, 1023), $urandom_range(0, 15),
                                        $urandom()));
                end
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
